@@ src/running_median_filter_macros.svh @@
// assertion macros shared by the filter modules
`ifndef RUNNING_MEDIAN_FILTER_MACROS_SVH
`define RUNNING_MEDIAN_FILTER_MACROS_SVH

// plain clocked property, checked outside reset
`define RMF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define RMF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/rmf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rmf_pkg;

    // window geometry and sample width
    localparam int WINDOW_SIZE = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int AGE_BITS    = $clog2(WINDOW_SIZE);
    localparam int FILL_BITS   = $clog2(WINDOW_SIZE);
    localparam int MID_INDEX   = WINDOW_SIZE / 2;

    localparam logic [AGE_BITS-1:0]  AGE_OLDEST = AGE_BITS'(WINDOW_SIZE - 1);
    localparam logic [FILL_BITS-1:0] FILL_MAX   = FILL_BITS'(WINDOW_SIZE - 1);

    // contents of one sorting cell
    typedef struct packed {
        logic                   valid;
        logic [AGE_BITS-1:0]    age;
        logic [SAMPLE_BITS-1:0] value;
    } cell_t;

endpackage

`default_nettype wire

@@ src/rmf_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "running_median_filter_macros.svh"

module rmf_cell
    import rmf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire cell_t                  lower,      // current contents of the cell below
    input  wire cell_t                  upper,      // current contents of the cell above
    input  wire logic                   del_in,     // oldest entry sits in a lower cell
    output logic                        del_out,    // oldest entry sits here or lower
    output cell_t                       state,
    output cell_t                       state_next
);

    cell_t state_reg;

    cell_t cur_src;
    cell_t low_src;
    logic  del_own;
    logic  cur_le;
    logic  low_le;
    logic  order_ok;

    // locate the oldest entry, it leaves the window on this item
    assign del_own = state_reg.valid && (state_reg.age == AGE_OLDEST);
    assign del_out = del_in || del_own;

    // list after removing the oldest entry: this slot and the one below
    assign cur_src = del_out ? upper : state_reg;
    assign low_src = del_in ? state_reg : lower;

    assign cur_le = cur_src.valid && (cur_src.value <= sample);
    assign low_le = low_src.valid && (low_src.value <= sample);

    // insert the new sample at its sorted place
    always_comb
    begin
        priority if (cur_le)
        begin
            state_next       = cur_src;
            state_next.age   = AGE_BITS'(cur_src.age + 1'b1);
        end
        else if (low_le)
        begin
            state_next.valid = 1'b1;
            state_next.age   = '0;
            state_next.value = sample;
        end
        else
        begin
            state_next       = low_src;
            state_next.age   = AGE_BITS'(low_src.age + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.valid <= 1'b0;
            state_reg.age   <= '0;
            state_reg.value <= '0;
        end
        else if (load)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

    assign order_ok = state_reg.valid && (state_reg.value <= upper.value);

    // window stays sorted and filled from the bottom
    `RMF_ASSERT_IMPLY(a_sorted, upper.valid, order_ok, "cell order broken")
    // no entry outlives the window
    `RMF_ASSERT_IMPLY(a_age_range, state_reg.valid, state_reg.age <= AGE_OLDEST, "age out of range")

endmodule

`default_nettype wire

@@ src/running_median_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Seven-tap running median filter for unsigned 16-bit samples.
// Input: s_tvalid/s_tready/s_tdata carries one sample per item.
// Output: m_tvalid/m_tready/m_tdata carries the median of the last seven
// samples, the current one included.
// The first six samples after reset only fill the window and give no output;
// from the seventh on every sample gives exactly one median.
// The window is a row of seven sorting cells; each item removes the oldest
// entry and inserts the new sample, so one sample per clock is taken unless the
// output stalls; the median appears on the output the cycle after acceptance.
// An output register holds the result; while it is full and m_tready is low,
// s_tready is low and the window holds still. The register is refilled in the
// cycle it is emptied, so with m_tready high throughput stays at one item per
// cycle. Reset empties the window and the output register; no clearing pass
// is needed.

`include "running_median_filter_macros.svh"

module running_median_filter
    import rmf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [SAMPLE_BITS-1:0] s_tdata,    // [15:0] sample
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [SAMPLE_BITS-1:0]      m_tdata     // [15:0] median
);

    cell_t                  cell_q    [WINDOW_SIZE];
    cell_t                  cell_d    [WINDOW_SIZE];
    logic  [WINDOW_SIZE:0]  del_chain;
    logic  [WINDOW_SIZE-1:0] valid_vec;

    logic                   accept;
    logic                   full;
    logic [FILL_BITS-1:0]   fill_count_reg;
    logic [FILL_BITS-1:0]   fill_count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] median_reg;
    logic                   fill_ok;

    // input handshake
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (fill_count_reg == FILL_MAX);

    // boundary of the cell row: floor below cell zero, empty slot above the top
    localparam cell_t FLOOR_CELL = '{valid: 1'b1, age: '0, value: '0};
    localparam cell_t EMPTY_CELL = '{valid: 1'b0, age: '0, value: '0};

    assign del_chain[0] = 1'b0;

    // row of sorting cells
    for (genvar i = 0; i < WINDOW_SIZE; i++)
    begin : g_cell
        cell_t lower_w;
        cell_t upper_w;

        if (i == 0)
        begin : g_bottom
            assign lower_w = FLOOR_CELL;
        end
        else
        begin : g_lower
            assign lower_w = cell_q[i-1];
        end

        if (i == WINDOW_SIZE - 1)
        begin : g_top
            assign upper_w = EMPTY_CELL;
        end
        else
        begin : g_upper
            assign upper_w = cell_q[i+1];
        end

        rmf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (accept),
            .sample     (s_tdata),
            .lower      (lower_w),
            .upper      (upper_w),
            .del_in     (del_chain[i]),
            .del_out    (del_chain[i+1]),
            .state      (cell_q[i]),
            .state_next (cell_d[i])
        );

        assign valid_vec[i] = cell_q[i].valid;
    end

    // fill counter, saturates once the window is full
    assign fill_count_next = full ? fill_count_reg : FILL_BITS'(fill_count_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else if (accept)
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // output register
    always_comb
    begin
        priority if (accept && full)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && full)
        begin
            median_reg <= cell_d[MID_INDEX].value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = median_reg;

    // occupied cells follow the fill count, one extra once the window is full
    assign fill_ok = ($countones(valid_vec) == fill_count_reg)
                     || (full && ($countones(valid_vec) == WINDOW_SIZE));

    // a fresh result only follows an item taken with a full window
    `RMF_ASSERT(a_result_src, $rose(out_valid_reg) |-> $past(accept && full), "stray result")
    // occupied cells track the fill count
    `RMF_ASSERT(a_fill_match, fill_ok, "cell occupancy mismatch")
    // the oldest entry exists only once the window is full
    `RMF_ASSERT_IMPLY(a_del_full, del_chain[WINDOW_SIZE], full && (&valid_vec), "early eviction")

endmodule

`default_nettype wire
